@@ hdl/mesh_vertex_normal_accumulator_assert.svh @@
// Assertion macros for the vertex normal accumulator.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define MVNA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define MVNA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mvna_pkg.sv @@
`default_nettype none

package mvna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = 10;
  localparam int COORD_W      = 24;
  localparam int NRM_W        = 16;
  localparam int THR_W        = 15;
  localparam int POS_W        = 3 * COORD_W;

  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_TRI  = 2'd1;
  localparam logic [1:0] FN_READ = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NRM_W-1:0]   nrm_t;

  function automatic coord_t sat_add24(input coord_t a, input nrm_t b);
    logic signed [COORD_W:0] s;
    coord_t r;
    s = {a[COORD_W-1], a} + {{(COORD_W-NRM_W+1){b[NRM_W-1]}}, b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic nrm_t sat16(input coord_t a);
    nrm_t r;
    if (a > 24'sd32767) begin
      r = 16'sd32767;
    end else if (a < -24'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = a[NRM_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/mvna_in_if.sv @@
`default_nettype none

interface mvna_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [9:0]        vertex_index;
  logic signed [23:0] coord_x;
  logic signed [23:0] coord_y;
  logic signed [23:0] coord_z;
  logic [9:0]        corner_a;
  logic [9:0]        corner_b;
  logic [9:0]        corner_c;

  modport source (output valid, func, vertex_index, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, func, vertex_index, coord_x, coord_y, coord_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

`default_nettype wire

@@ hdl/mvna_out_if.sv @@
`default_nettype none

interface mvna_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         normal_vertex;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               was_normalized;

  modport source (output valid, normal_vertex, normal_x, normal_y, normal_z,
                  was_normalized, input ready);
  modport sink (input valid, normal_vertex, normal_x, normal_y, normal_z,
                was_normalized, output ready);
endinterface

`default_nettype wire

@@ hdl/mvna_cfg_if.sv @@
`default_nettype none

interface mvna_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hdl/mvna_ram.sv @@
`default_nettype none

module mvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/mvna_mul.sv @@
`default_nettype none

module mvna_mul (
  input  logic               clk_i,
  input  logic signed [30:0] a_i,
  input  logic signed [30:0] b_i,
  output logic signed [61:0] p_o
);

  logic signed [61:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 62'(a_i) * 62'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ hdl/mvna_root.sv @@
`default_nettype none

module mvna_root (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [61:0] x_i,
  output logic        done_o,
  output logic [30:0] root_o
);

  logic        busy_q, done_q;
  logic [61:0] rem_q, r_q, bit_q;
  logic [61:0] trial;
  logic        ge;

  assign trial = r_q + bit_q;
  assign ge    = rem_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= x_i;
      r_q   <= '0;
      bit_q <= 62'd1 << 60;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - trial;
        r_q   <= (r_q >> 1) + bit_q;
      end else begin
        r_q   <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[30:0];

endmodule

`default_nettype wire

@@ hdl/mvna_div.sv @@
`default_nettype none

module mvna_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [29:0] mag_i,
  input  logic [30:0] norm_i,
  output logic        done_o,
  output logic [14:0] q_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [46:0] rem_q, dv_q;
  logic [16:0] quo_q;
  logic        ge;

  assign ge = rem_q >= dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {2'b0, mag_i, 15'b0} + {17'b0, norm_i[30:1]};
      dv_q  <= {norm_i, 16'b0};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dv_q;
      end
      quo_q <= {quo_q[15:0], ge};
      dv_q  <= dv_q >> 1;
    end
  end

  assign done_o = done_q;
  assign q_o    = (quo_q > 17'd32767) ? 15'h7fff : quo_q[14:0];

endmodule

`default_nettype wire

@@ hdl/mesh_vertex_normal_accumulator.sv @@
// Per-vertex normal accumulator for a triangle mesh. A load (func 0) clears the vertex's
// sum; a triangle (func 1) passes through the shared 31x31 multiplier (six cross-product
// terms, three squares and the threshold's square), the normalizing shift, the bit-pair
// square root, three restoring divisions and three read-modify-write passes over the sum
// memory; a degenerate triangle ends after the cross product with the sums untouched. A
// read (func 2) returns the sum raw, or renormalized when its squared length exceeds the
// squared threshold, and then waits for the output register to be free.
// The block takes one item at a time; a finished result waits in the
// output register while the next item is accepted. Position and sum memories are not
// cleared at reset: an entry reads as garbage until loaded.
`default_nettype none
`include "mesh_vertex_normal_accumulator_assert.svh"

module mesh_vertex_normal_accumulator (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvna_in_if.sink    in_i,
  mvna_cfg_if.sink   cfg_i,
  mvna_out_if.source out_o
);
  import mvna_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_TRD    = 4'd2;
  localparam logic [3:0] S_DIFF   = 4'd3;
  localparam logic [3:0] S_CROSS  = 4'd4;
  localparam logic [3:0] S_MAG    = 4'd5;
  localparam logic [3:0] S_SHIFT  = 4'd6;
  localparam logic [3:0] S_SQ     = 4'd7;
  localparam logic [3:0] S_ROOT   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_RMW_RD = 4'd10;
  localparam logic [3:0] S_RMW_WR = 4'd11;
  localparam logic [3:0] S_RRD    = 4'd12;
  localparam logic [3:0] S_RGET   = 4'd13;
  localparam logic [3:0] S_RCMP   = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  logic [3:0]       state_q, state_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [1:0]       ci_q, ci_d;
  logic [1:0]       func_q, func_d;
  logic [IDX_W-1:0] vidx_q, vidx_d, ca_q, ca_d, cb_q, cb_d, cc_q, cc_d;
  coord_t           ldx_q, ldx_d, ldy_q, ldy_d, ldz_q, ldz_d;
  coord_t           pos_q [3][3];
  coord_t           pos_d [3][3];
  coord_t           sraw_q [3];
  coord_t           sraw_d [3];
  logic signed [24:0] u_q [3];
  logic signed [24:0] u_d [3];
  logic signed [24:0] v_q [3];
  logic signed [24:0] v_d [3];
  logic signed [50:0] n_q [3];
  logic signed [50:0] n_d [3];
  logic [50:0]      mg_q [3];
  logic [50:0]      mg_d [3];
  logic [2:0]       neg_q, neg_d;
  logic [61:0]      sum_q, sum_d;
  logic [29:0]      thr2_q, thr2_d;
  logic [30:0]      norm_q, norm_d;
  nrm_t             res_q [3];
  nrm_t             res_d [3];
  logic             flag_q, flag_d;
  logic [THR_W-1:0] thr_q;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_vtx_q, out_vtx_d;
  nrm_t             out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic             out_flag_q, out_flag_d;

  logic               pos_we, sum_we;
  logic [IDX_W-1:0]   pos_raddr, sum_raddr, sum_waddr, corner_sel;
  logic [POS_W-1:0]   pos_rdata, sum_rdata, sum_wdata;
  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] prod;
  logic               root_start, root_done, div_start, div_done;
  logic [30:0]        root_r;
  logic [14:0]        div_q;
  logic [2:0]         cm1;
  logic signed [24:0] se;

  mvna_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i, .we_i(pos_we), .waddr_i(vidx_q), .wdata_i({ldz_q, ldy_q, ldx_q}),
    .raddr_i(pos_raddr), .rdata_o(pos_rdata)
  );

  mvna_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i, .we_i(sum_we), .waddr_i(sum_waddr), .wdata_i(sum_wdata),
    .raddr_i(sum_raddr), .rdata_o(sum_rdata)
  );

  mvna_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  mvna_root u_root (
    .clk_i, .rst_ni, .start_i(root_start), .x_i(sum_q), .done_o(root_done), .root_o(root_r)
  );

  mvna_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .mag_i(mg_q[ci_q][29:0]), .norm_i(norm_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.normal_vertex  = out_vtx_q;
  assign out_o.normal_x       = out_x_q;
  assign out_o.normal_y       = out_y_q;
  assign out_o.normal_z       = out_z_q;
  assign out_o.was_normalized = out_flag_q;

  assign cm1 = cnt_q - 3'd1;

  always_comb begin
    case (ci_q)
      2'd0:    corner_sel = ca_q;
      2'd1:    corner_sel = cb_q;
      default: corner_sel = cc_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ci_d    = ci_q;
    func_d  = func_q;
    vidx_d  = vidx_q;
    ca_d    = ca_q;
    cb_d    = cb_q;
    cc_d    = cc_q;
    ldx_d   = ldx_q;
    ldy_d   = ldy_q;
    ldz_d   = ldz_q;
    pos_d   = pos_q;
    sraw_d  = sraw_q;
    u_d     = u_q;
    v_d     = v_q;
    n_d     = n_q;
    mg_d    = mg_q;
    neg_d   = neg_q;
    sum_d   = sum_q;
    thr2_d  = thr2_q;
    norm_d  = norm_q;
    res_d   = res_q;
    flag_d  = flag_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_vtx_d   = out_vtx_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_z_d     = out_z_q;
    out_flag_d  = out_flag_q;
    pos_we     = 1'b0;
    sum_we     = 1'b0;
    pos_raddr  = ca_q;
    sum_raddr  = vidx_q;
    sum_waddr  = vidx_q;
    sum_wdata  = '0;
    mul_a      = '0;
    mul_b      = '0;
    root_start = 1'b0;
    div_start  = 1'b0;
    se         = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          func_d = in_i.func;
          vidx_d = in_i.vertex_index;
          ldx_d  = in_i.coord_x;
          ldy_d  = in_i.coord_y;
          ldz_d  = in_i.coord_z;
          ca_d   = in_i.corner_a;
          cb_d   = in_i.corner_b;
          cc_d   = in_i.corner_c;
          cnt_d  = '0;
          case (in_i.func)
            FN_LOAD: state_d = S_LOAD;
            FN_TRI:  state_d = S_TRD;
            FN_READ: state_d = S_RRD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        pos_we  = 1'b1;
        sum_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_TRD: begin
        case (cnt_q)
          3'd0:    pos_raddr = ca_q;
          3'd1:    pos_raddr = cb_q;
          default: pos_raddr = cc_q;
        endcase
        if (cnt_q != 3'd0) begin
          for (int ax = 0; ax < 3; ax++) begin
            pos_d[cm1[1:0]][ax] = pos_rdata[COORD_W*ax +: COORD_W];
          end
        end
        if (cnt_q == 3'd3) begin
          state_d = S_DIFF;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_DIFF: begin
        for (int ax = 0; ax < 3; ax++) begin
          u_d[ax] = {pos_q[1][ax][COORD_W-1], pos_q[1][ax]}
                  - {pos_q[0][ax][COORD_W-1], pos_q[0][ax]};
          v_d[ax] = {pos_q[2][ax][COORD_W-1], pos_q[2][ax]}
                  - {pos_q[1][ax][COORD_W-1], pos_q[1][ax]};
        end
        cnt_d   = '0;
        state_d = S_CROSS;
      end
      S_CROSS: begin
        case (cnt_q)
          3'd0: begin mul_a = 31'(u_q[1]); mul_b = 31'(v_q[2]); end
          3'd1: begin mul_a = 31'(u_q[2]); mul_b = 31'(v_q[1]); end
          3'd2: begin mul_a = 31'(u_q[2]); mul_b = 31'(v_q[0]); end
          3'd3: begin mul_a = 31'(u_q[0]); mul_b = 31'(v_q[2]); end
          3'd4: begin mul_a = 31'(u_q[0]); mul_b = 31'(v_q[1]); end
          3'd5: begin mul_a = 31'(u_q[1]); mul_b = 31'(v_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_q != 3'd0) begin
          if (!cm1[0]) begin
            n_d[cm1[2:1]] = prod[50:0];
          end else begin
            n_d[cm1[2:1]] = n_q[cm1[2:1]] - prod[50:0];
          end
        end
        if (cnt_q == 3'd6) begin
          state_d = S_MAG;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mg_d[i]  = n_q[i][50] ? 51'(-n_q[i]) : 51'(n_q[i]);
          neg_d[i] = n_q[i][50];
        end
        if (n_q[0] == '0 && n_q[1] == '0 && n_q[2] == '0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (|{mg_q[0][50:30], mg_q[1][50:30], mg_q[2][50:30]}) begin
          for (int i = 0; i < 3; i++) begin
            mg_d[i] = mg_q[i] >> 1;
          end
        end else begin
          cnt_d   = '0;
          sum_d   = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        if (cnt_q < 3'd3) begin
          mul_a = {1'b0, mg_q[cnt_q[1:0]][29:0]};
          mul_b = {1'b0, mg_q[cnt_q[1:0]][29:0]};
        end else begin
          mul_a = {16'b0, thr_q};
          mul_b = {16'b0, thr_q};
        end
        if (cnt_q != 3'd0 && cnt_q != 3'd4) begin
          sum_d = sum_q + prod[61:0];
        end
        if (cnt_q == 3'd4) begin
          thr2_d = prod[29:0];
          cnt_d  = '0;
          if (func_q == FN_TRI) begin
            state_d = S_ROOT;
          end else begin
            state_d = S_RCMP;
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_RCMP: begin
        cnt_d = '0;
        if (sum_q > {32'b0, thr2_q}) begin
          flag_d  = 1'b1;
          state_d = S_ROOT;
        end else begin
          flag_d  = 1'b0;
          for (int i = 0; i < 3; i++) begin
            res_d[i] = sat16(sraw_q[i]);
          end
          state_d = S_EMIT;
        end
      end
      S_ROOT: begin
        root_start = (cnt_q == 3'd0);
        cnt_d      = 3'd1;
        if (root_done) begin
          norm_d  = root_r;
          ci_d    = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        div_start = (cnt_q == 3'd0);
        cnt_d     = 3'd1;
        if (div_done) begin
          res_d[ci_q] = neg_q[ci_q] ? -{1'b0, div_q} : {1'b0, div_q};
          cnt_d       = '0;
          if (ci_q == 2'd2) begin
            ci_d    = '0;
            state_d = (func_q == FN_TRI) ? S_RMW_RD : S_EMIT;
          end else begin
            ci_d = ci_q + 2'd1;
          end
        end
      end
      S_RMW_RD: begin
        sum_raddr = corner_sel;
        state_d   = S_RMW_WR;
      end
      S_RMW_WR: begin
        sum_we    = 1'b1;
        sum_waddr = corner_sel;
        for (int ax = 0; ax < 3; ax++) begin
          sum_wdata[COORD_W*ax +: COORD_W] =
            sat_add24(sum_rdata[COORD_W*ax +: COORD_W], res_q[ax]);
        end
        if (ci_q == 2'd2) begin
          state_d = S_IDLE;
        end else begin
          ci_d    = ci_q + 2'd1;
          state_d = S_RMW_RD;
        end
      end
      S_RRD: begin
        sum_raddr = vidx_q;
        state_d   = S_RGET;
      end
      S_RGET: begin
        for (int i = 0; i < 3; i++) begin
          sraw_d[i] = sum_rdata[COORD_W*i +: COORD_W];
          se        = {sum_rdata[COORD_W*i+COORD_W-1], sum_rdata[COORD_W*i +: COORD_W]};
          mg_d[i]   = {26'b0, se[24] ? -se : se};
          neg_d[i]  = se[24];
        end
        cnt_d   = '0;
        sum_d   = '0;
        state_d = S_SQ;
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_vtx_d   = vidx_q;
          out_x_d     = res_q[0];
          out_y_d     = res_q[1];
          out_z_d     = res_q[2];
          out_flag_d  = flag_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ci_q        <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= 15'd1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ci_q        <= ci_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        thr_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    vidx_q     <= vidx_d;
    ca_q       <= ca_d;
    cb_q       <= cb_d;
    cc_q       <= cc_d;
    ldx_q      <= ldx_d;
    ldy_q      <= ldy_d;
    ldz_q      <= ldz_d;
    pos_q      <= pos_d;
    sraw_q     <= sraw_d;
    u_q        <= u_d;
    v_q        <= v_d;
    n_q        <= n_d;
    mg_q       <= mg_d;
    neg_q      <= neg_d;
    sum_q      <= sum_d;
    thr2_q     <= thr2_d;
    norm_q     <= norm_d;
    res_q      <= res_d;
    flag_q     <= flag_d;
    out_vtx_q  <= out_vtx_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_z_q    <= out_z_d;
    out_flag_q <= out_flag_d;
  end

  `MVNA_ASSERT_IMP(a_emit_read, state_q == S_EMIT, func_q == FN_READ, "emit without read")
  `MVNA_ASSERT_IMP(a_div_norm, div_start, norm_q != '0, "divide by zero norm")
  `MVNA_ASSERT_IMP(a_out_from_emit, $rose(out_valid_q), $past(state_q) == S_EMIT,
                   "result not from emit")
  `MVNA_ASSERT_NXT(a_load_one, state_q == S_LOAD, state_q == S_IDLE, "load overran")

endmodule

`default_nettype wire
